>>> rtl/core/gmdfs_pkg.sv
`default_nettype none

package gmdfs_pkg;

  localparam int unsigned Rows   = 8;
  localparam int unsigned Cols   = 8;
  localparam int unsigned Cells  = Rows * Cols;
  localparam int unsigned RowW   = $clog2(Rows);
  localparam int unsigned ColW   = $clog2(Cols);
  localparam int unsigned CellW  = RowW + ColW;
  localparam int unsigned DepthW = $clog2(Cells) + 1;
  localparam int unsigned DirW   = 3;
  localparam int unsigned StepsW = 7;

  // search directions, tried in this order
  localparam logic [DirW-1:0] DirRight = 3'd0;
  localparam logic [DirW-1:0] DirDown  = 3'd1;
  localparam logic [DirW-1:0] DirLeft  = 3'd2;
  localparam logic [DirW-1:0] DirUp    = 3'd3;
  localparam logic [DirW-1:0] DirDone  = 3'd4;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpSolve = 1'b1;

  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);
  localparam logic [ColW-1:0] LastCol = ColW'(Cols - 1);

  typedef struct packed {
    logic [CellW-1:0] pos;
    logic [DirW-1:0]  dir;
  } stack_entry_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [CellW-1:0]      waddr;
    logic [CellW-1:0]      raddr;
    stack_entry_t          wdata;
  } stack_req_t;

  typedef struct packed {
    logic [RowW-1:0]   cell_row;
    logic [ColW-1:0]   cell_col;
    logic [StepsW-1:0] steps_to_exit;
    logic              found;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_push_t;

endpackage

`default_nettype wire

>>> rtl/core/gmdfs_if.sv
`default_nettype none

interface gmdfs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] row_index;
  logic [7:0] row_walls;

  modport source (output valid, op, row_index, row_walls, input ready);
  modport sink   (input valid, op, row_index, row_walls, output ready);
endinterface

interface gmdfs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] cell_row;
  logic [2:0] cell_col;
  logic [6:0] steps_to_exit;
  logic       found;
  logic       last;

  modport source (output valid, cell_row, cell_col, steps_to_exit, found, last,
                  input ready);
  modport sink   (input valid, cell_row, cell_col, steps_to_exit, found, last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/gmdfs_stack_mem.sv
`default_nettype none

module gmdfs_stack_mem
  import gmdfs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire stack_req_t   req_i,
  output stack_entry_t      rdata_o
);

  stack_entry_t mem [Cells];
  stack_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/gmdfs_engine.sv
`default_nettype none

module gmdfs_engine
  import gmdfs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_op_i,
  input  wire logic [RowW-1:0] in_row_i,
  input  wire logic [7:0]      in_walls_i,
  output logic                 in_ready_o,
  input  wire logic            slot_free_i,
  output res_push_t            res_o,
  output stack_req_t           stack_req_o,
  input  wire stack_entry_t    stack_rdata_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_POPW = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_TOP  = 3'd5;
  localparam logic [2:0] ST_EXIT = 3'd6;
  localparam logic [2:0] ST_NONE = 3'd7;

  localparam logic [CellW-1:0] ExitCell = CellW'(Cells - 1);

  logic [2:0]                 state_q, state_d;
  logic [Rows-1:0][Cols-1:0]  wall_q;
  logic [Cells-1:0]           visited_q, visited_d;
  logic [CellW-1:0]           top_cell_q, top_cell_d;
  logic [DirW-1:0]            top_dir_q, top_dir_d;
  logic [DepthW-1:0]          depth_q, depth_d;
  logic [CellW-1:0]           k_q, k_d;

  logic [RowW-1:0]  cur_r, nbr_r;
  logic [ColW-1:0]  cur_c, nbr_c;
  logic [CellW-1:0] nbr_cell;
  logic             nbr_inb, nbr_open;
  logic             accept_in;
  logic [StepsW-1:0] steps_k;

  assign accept_in  = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  assign cur_r = top_cell_q[CellW-1:ColW];
  assign cur_c = top_cell_q[ColW-1:0];

  always_comb begin
    nbr_r   = cur_r;
    nbr_c   = cur_c;
    nbr_inb = 1'b0;
    case (top_dir_q)
      DirRight: begin
        nbr_inb = (cur_c != LastCol);
        nbr_c   = cur_c + ColW'(1);
      end
      DirDown: begin
        nbr_inb = (cur_r != LastRow);
        nbr_r   = cur_r + RowW'(1);
      end
      DirLeft: begin
        nbr_inb = (cur_c != '0);
        nbr_c   = cur_c - ColW'(1);
      end
      DirUp: begin
        nbr_inb = (cur_r != '0);
        nbr_r   = cur_r - RowW'(1);
      end
      default: nbr_inb = 1'b0;
    endcase
  end

  assign nbr_cell = {nbr_r, nbr_c};
  assign nbr_open = nbr_inb && !wall_q[nbr_r][nbr_c] && !visited_q[nbr_cell];

  // path length is depth + 1; entry k is (depth + 1 - k) cells from the exit
  assign steps_k = StepsW'(depth_q) + StepsW'(1) - StepsW'(k_q);

  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    top_cell_d  = top_cell_q;
    top_dir_d   = top_dir_q;
    depth_d     = depth_q;
    k_d         = k_q;
    res_o       = '0;
    stack_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept_in && (in_op_i == OpSolve)) begin
          visited_d    = '0;
          visited_d[0] = 1'b1;
          top_cell_d   = '0;
          top_dir_d    = DirRight;
          depth_d      = DepthW'(1);
          state_d      = ST_STEP;
        end
      end
      ST_STEP: begin
        if (top_dir_q == DirDone) begin
          if (depth_q == DepthW'(1)) begin
            state_d = ST_NONE;
          end else begin
            stack_req_o.re    = 1'b1;
            stack_req_o.raddr = CellW'(depth_q - DepthW'(2));
            depth_d           = depth_q - DepthW'(1);
            state_d           = ST_POPW;
          end
        end else begin
          top_dir_d = top_dir_q + DirW'(1);
          if (nbr_open) begin
            if (nbr_cell == ExitCell) begin
              k_d     = '0;
              state_d = (depth_q == DepthW'(1)) ? ST_TOP : ST_RD;
            end else begin
              visited_d[nbr_cell]  = 1'b1;
              stack_req_o.we       = 1'b1;
              stack_req_o.waddr    = CellW'(depth_q - DepthW'(1));
              stack_req_o.wdata    = '{pos: top_cell_q, dir: top_dir_q + DirW'(1)};
              top_cell_d           = nbr_cell;
              top_dir_d            = DirRight;
              depth_d              = depth_q + DepthW'(1);
            end
          end
        end
      end
      ST_POPW: begin
        top_cell_d = stack_rdata_i.pos;
        top_dir_d  = stack_rdata_i.dir;
        state_d    = ST_STEP;
      end
      ST_RD: begin
        stack_req_o.re    = 1'b1;
        stack_req_o.raddr = k_q;
        state_d           = ST_WR;
      end
      ST_WR: begin
        if (slot_free_i) begin
          res_o.valid              = 1'b1;
          res_o.data.cell_row      = stack_rdata_i.pos[CellW-1:ColW];
          res_o.data.cell_col      = stack_rdata_i.pos[ColW-1:0];
          res_o.data.steps_to_exit = steps_k;
          res_o.data.found         = 1'b1;
          k_d                      = k_q + CellW'(1);
          state_d = (DepthW'(k_q) == depth_q - DepthW'(2)) ? ST_TOP : ST_RD;
        end
      end
      ST_TOP: begin
        if (slot_free_i) begin
          res_o.valid              = 1'b1;
          res_o.data.cell_row      = cur_r;
          res_o.data.cell_col      = cur_c;
          res_o.data.steps_to_exit = StepsW'(2);
          res_o.data.found         = 1'b1;
          state_d                  = ST_EXIT;
        end
      end
      ST_EXIT: begin
        if (slot_free_i) begin
          res_o.valid              = 1'b1;
          res_o.data.cell_row      = LastRow;
          res_o.data.cell_col      = LastCol;
          res_o.data.steps_to_exit = StepsW'(1);
          res_o.data.found         = 1'b1;
          res_o.data.last          = 1'b1;
          state_d                  = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (slot_free_i) begin
          res_o.valid     = 1'b1;
          res_o.data.last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wall_q    <= '0;
      visited_q <= '0;
      depth_q   <= '0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      depth_q   <= depth_d;
      if (accept_in && (in_op_i == OpLoad)) begin
        wall_q[in_row_i] <= in_walls_i[Cols-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_cell_q <= top_cell_d;
    top_dir_q  <= top_dir_d;
    k_q        <= k_d;
  end

`ifndef SYNTHESIS
  a_solve_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && (in_op_i == OpSolve)) |=> (state_q == ST_STEP && depth_q == DepthW'(1)))
    else $error("solve did not start the search");
  a_start_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (visited_q[0] && depth_q != '0))
    else $error("search running without start cell");
  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_req_o.we |-> (depth_q < DepthW'(Cells)))
    else $error("stack overflow");
  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> slot_free_i)
    else $error("result pushed into a full output slot");
  a_no_mem_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stack_req_o.we && stack_req_o.re))
    else $error("stack read and write in one cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/core/grid_maze_dfs_path_finder_unit.sv
`default_nettype none

// Maze path finder over an 8 x 8 wall map, depth-first search from (0,0) to (7,7).
// Input channel in_i: op = 0 loads row_index with row_walls (no result),
// op = 1 solves. Output channel out_o: one transaction per path cell, start
// cell first, steps_to_exit counting down to 1 at the exit, last on the exit.
// With no path, a single transaction with found = 0, last = 1 and zeros.
// A solve tries one direction at a time; a backtrack issues a stack memory read
// (its read data is registered) and then restores the popped entry. The path
// is then emitted with a stack memory read and then an output load per path cell
// below the top of stack, and one output load each for the top cell and the exit.
// The search state (stack) lives in one synchronous memory; walls and visited
// marks are flops. A new item is taken only when the previous solve has handed
// its last transaction to the output register, which may still be waiting.
// A stall on out_o holds the output register and freezes the emission.
// Reset clears the wall map to all open and the output valid flag; the stack
// memory needs no clearing.

module grid_maze_dfs_path_finder_unit
  import gmdfs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gmdfs_in_if.sink   in_i,
  gmdfs_out_if.source out_o
);

  res_push_t    res;
  stack_req_t   stack_req;
  stack_entry_t stack_rdata;
  logic         slot_free;
  logic         out_valid_q;
  result_t      out_data_q;

  assign slot_free = !out_valid_q || out_o.ready;

  gmdfs_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_op_i       (in_i.op),
    .in_row_i      (in_i.row_index),
    .in_walls_i    (in_i.row_walls),
    .in_ready_o    (in_i.ready),
    .slot_free_i   (slot_free),
    .res_o         (res),
    .stack_req_o   (stack_req),
    .stack_rdata_i (stack_rdata)
  );

  gmdfs_stack_mem u_stack (
    .clk_i   (clk_i),
    .req_i   (stack_req),
    .rdata_o (stack_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cell_row      = out_data_q.cell_row;
  assign out_o.cell_col      = out_data_q.cell_col;
  assign out_o.steps_to_exit = out_data_q.steps_to_exit;
  assign out_o.found         = out_data_q.found;
  assign out_o.last          = out_data_q.last;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled output transaction changed");
  a_no_path_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.found) |->
      (out_data_q.last && out_data_q.steps_to_exit == '0))
    else $error("malformed no-path transaction");
  a_exit_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.found && out_data_q.last) |->
      (out_data_q.steps_to_exit == StepsW'(1)))
    else $error("exit cell not one step from exit");
`endif

endmodule

`default_nettype wire

>>> bench/grid_maze_dfs_path_finder_unit_test.sv
`timescale 1ns / 100ps

module grid_maze_dfs_path_finder_unit_test
  import gmdfs_pkg::*;
();

  localparam int CycleLimit = 4_000_000;
  localparam int RandomItems = 300;
  localparam int DrainCycles = 400;
  localparam int MaxPrinted = 40;

  typedef enum logic {BY_MODEL, NO_PATH} exp_src_e;

  typedef struct packed {
    exp_src_e   src;
    logic       op;
    logic [2:0] row;
    logic [7:0] walls;
  } directed_row_t;

  localparam int NDirected = 24;

  // typed rows (NO_PATH) carry their expectation; all others go through the predictor
  directed_row_t directed_tbl [NDirected] = '{
    '{BY_MODEL, OpSolve, 3'd0, 8'h00},  // open grid straight after reset
    '{BY_MODEL, OpLoad,  3'd0, 8'h01},  // wall on the start cell, ignored
    '{BY_MODEL, OpSolve, 3'd0, 8'h00},
    '{BY_MODEL, OpLoad,  3'd7, 8'h80},  // wall on the exit cell
    '{NO_PATH,  OpSolve, 3'd0, 8'h00},
    '{BY_MODEL, OpLoad,  3'd7, 8'h00},
    '{BY_MODEL, OpLoad,  3'd4, 8'hFF},  // full wall row cuts the grid
    '{NO_PATH,  OpSolve, 3'd7, 8'hFF},
    '{BY_MODEL, OpLoad,  3'd4, 8'h00},
    '{BY_MODEL, OpLoad,  3'd0, 8'hFE},  // start boxed in
    '{BY_MODEL, OpLoad,  3'd1, 8'hFF},
    '{NO_PATH,  OpSolve, 3'd0, 8'h00},
    '{BY_MODEL, OpLoad,  3'd0, 8'h00},  // serpentine with dead ends
    '{BY_MODEL, OpLoad,  3'd1, 8'h7F},
    '{BY_MODEL, OpLoad,  3'd2, 8'h00},
    '{BY_MODEL, OpLoad,  3'd3, 8'hFE},
    '{BY_MODEL, OpLoad,  3'd4, 8'h00},
    '{BY_MODEL, OpLoad,  3'd5, 8'h7F},
    '{BY_MODEL, OpLoad,  3'd6, 8'h00},
    '{BY_MODEL, OpSolve, 3'd0, 8'h00},
    '{BY_MODEL, OpLoad,  3'd2, 8'h55},
    '{BY_MODEL, OpLoad,  3'd6, 8'hAA},
    '{BY_MODEL, OpSolve, 3'd5, 8'h2C},
    '{BY_MODEL, OpSolve, 3'd0, 8'h00}   // repeat solve, visited marks start over
  };

  logic clk_i;
  logic rst_ni;

  gmdfs_in_if  cmd_if ();
  gmdfs_out_if path_if ();

  grid_maze_dfs_path_finder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (path_if)
  );

  logic [Cols-1:0] maze_walls [Rows];
  result_t path_cells_q [$];

  int mismatch_count;
  int cycle_count;
  int load_count;
  int solve_count;
  int blocked_count;
  int checked_count;
  bit no_idle;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what, input int exp_v, input int got_v);
    if (mismatch_count < MaxPrinted) begin
      $display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    end
    mismatch_count++;
  endtask

  // appends one expected transaction at the tail of the queue
  function automatic void queue_result(input result_t r);
    path_cells_q.insert(path_cells_q.size(), r);
  endfunction

  function automatic result_t no_path_result();
    result_t res;
    res = '0;
    res.last = 1'b1;
    return res;
  endfunction

  // depth-first search over the predicted wall map; queues one entry per path cell, or one no-path entry
  function automatic void plan_path();
    logic [Cols-1:0] seen [Rows];
    int stk_row [Cells];
    int stk_col [Cells];
    logic [DirW-1:0] stk_dir [Cells];
    logic [DirW-1:0] d;
    int depth;
    int nr;
    int nc;
    result_t res;
    for (int i = 0; i < Rows; i++) seen[i] = '0;
    depth = 1;
    stk_row[0] = 0;
    stk_col[0] = 0;
    stk_dir[0] = DirRight;
    seen[0][0] = 1'b1;
    while (depth > 0) begin
      d = stk_dir[depth-1];
      if (d == DirDone) begin
        depth--;
        continue;
      end
      stk_dir[depth-1] = d + 1'b1;
      nr = stk_row[depth-1];
      nc = stk_col[depth-1];
      case (d)
        DirRight: nc++;
        DirDown:  nr++;
        DirLeft:  nc--;
        default:  nr--;
      endcase
      if (nr < 0 || nr >= int'(Rows) || nc < 0 || nc >= int'(Cols)) continue;
      if (maze_walls[nr][nc] || seen[nr][nc]) continue;
      if (nr == int'(LastRow) && nc == int'(LastCol)) begin
        for (int k = 0; k < depth; k++) begin
          res.cell_row = RowW'(stk_row[k]);
          res.cell_col = ColW'(stk_col[k]);
          res.steps_to_exit = StepsW'(depth + 1 - k);
          res.found = 1'b1;
          res.last = 1'b0;
          queue_result(res);
        end
        res.cell_row = LastRow;
        res.cell_col = LastCol;
        res.steps_to_exit = StepsW'(1);
        res.found = 1'b1;
        res.last = 1'b1;
        queue_result(res);
        return;
      end
      seen[nr][nc] = 1'b1;
      stk_row[depth] = nr;
      stk_col[depth] = nc;
      stk_dir[depth] = DirRight;
      depth++;
    end
    blocked_count++;
    queue_result(no_path_result());
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transaction on the command channel; valid stays high when the next has no gap
  task automatic send_cmd(input logic op, input logic [2:0] row, input logic [7:0] walls,
                          input exp_src_e src);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.op <= op;
    cmd_if.row_index <= row;
    cmd_if.row_walls <= walls;
    do @(posedge clk_i); while (!cmd_if.ready);
    if (op == OpLoad) begin
      maze_walls[row] = walls;
      load_count++;
    end else begin
      solve_count++;
      if (src == NO_PATH) begin
        blocked_count++;
        queue_result(no_path_result());
      end else begin
        plan_path();
      end
    end
  endtask

  function automatic logic [7:0] wall_row(input int pct);
    logic [7:0] w;
    for (int j = 0; j < 8; j++) w[j] = ($urandom_range(99) < pct);
    return w;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && path_if.valid && path_if.ready) begin
      got.cell_row = path_if.cell_row;
      got.cell_col = path_if.cell_col;
      got.steps_to_exit = path_if.steps_to_exit;
      got.found = path_if.found;
      got.last = path_if.last;
      if (path_cells_q.size() == 0) begin
        note_mismatch("unexpected transaction (steps_to_exit)", -1, got.steps_to_exit);
      end else begin
        want = path_cells_q.pop_front();
        checked_count++;
        if (got.cell_row != want.cell_row)
          note_mismatch("cell_row", want.cell_row, got.cell_row);
        if (got.cell_col != want.cell_col)
          note_mismatch("cell_col", want.cell_col, got.cell_col);
        if (got.steps_to_exit != want.steps_to_exit)
          note_mismatch("steps_to_exit", want.steps_to_exit, got.steps_to_exit);
        if (got.found != want.found)
          note_mismatch("found", want.found, got.found);
        if (got.last != want.last)
          note_mismatch("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d transactions still expected",
               cycle_count, path_cells_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side stalls: mostly short, a few long, no new ones start while no_idle is set
  initial begin
    int stall_left;
    stall_left = 0;
    path_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        path_if.ready <= 1'b0;
        stall_left--;
      end else begin
        path_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(99) < 20) begin
          stall_left = ($urandom_range(99) < 90) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    int items;
    int pct;
    int kind;
    int order [8];
    int tmp;
    int j;
    mismatch_count = 0;
    cycle_count = 0;
    load_count = 0;
    solve_count = 0;
    blocked_count = 0;
    checked_count = 0;
    no_idle = 1'b0;
    for (int i = 0; i < Rows; i++) maze_walls[i] = '0;
    cmd_if.valid = 1'b0;
    cmd_if.op = OpLoad;
    cmd_if.row_index = '0;
    cmd_if.row_walls = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tbl[i]) begin
      send_cmd(directed_tbl[i].op, directed_tbl[i].row, directed_tbl[i].walls,
               directed_tbl[i].src);
    end

    items = 0;
    while (items < RandomItems) begin
      // hold off the sender until the block has emptied its result stream
      if (items == 0 || $urandom_range(99) < 10) begin
        @(negedge clk_i);
        cmd_if.valid <= 1'b0;
        while (path_cells_q.size() != 0) @(posedge clk_i);
      end
      no_idle = ($urandom_range(99) < 20);
      case ($urandom_range(4))
        0: pct = 5;
        1: pct = 15;
        2: pct = 25;
        3: pct = 35;
        default: pct = 50;
      endcase
      kind = $urandom_range(99);
      if (kind < 70) begin
        // whole maze in shuffled row order, then one or two solves
        for (int i = 0; i < 8; i++) order[i] = i;
        for (int i = 7; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < 8; i++) begin
          send_cmd(OpLoad, 3'(order[i]), wall_row(pct), BY_MODEL);
        end
        send_cmd(OpSolve, 3'($urandom), 8'($urandom), BY_MODEL);
        items += 9;
        if ($urandom_range(99) < 20) begin
          send_cmd(OpSolve, 3'($urandom), 8'($urandom), BY_MODEL);
          items++;
        end
      end else if (kind < 85) begin
        tmp = $urandom_range(1, 3);
        for (int i = 0; i < tmp; i++) begin
          send_cmd(OpLoad, 3'($urandom), wall_row(pct), BY_MODEL);
        end
        send_cmd(OpSolve, 3'($urandom), 8'($urandom), BY_MODEL);
        items += tmp + 1;
      end else begin
        tmp = $urandom_range(2, 6);
        for (int i = 0; i < tmp; i++) begin
          send_cmd(1'($urandom), 3'($urandom), 8'($urandom), BY_MODEL);
        end
        items += tmp;
      end
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;

    while (path_cells_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d row loads and %0d solves, %0d of them without a path",
             load_count, solve_count, blocked_count);
    $display("checked %0d path transactions, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/gmdfs_pkg.sv
rtl/core/gmdfs_if.sv
rtl/core/gmdfs_stack_mem.sv
rtl/core/gmdfs_engine.sv
rtl/core/grid_maze_dfs_path_finder_unit.sv
bench/grid_maze_dfs_path_finder_unit_test.sv
